// ===== sv/dcf_pkg.sv =====
// Shared types, constants and the CRC-16 byte update for the command framer.
package dcf_pkg;

  // Frame geometry
  localparam int MAX_PAYLOAD_BYTES = 8;
  localparam int BODY_BYTES        = MAX_PAYLOAD_BYTES + 4;
  localparam int LEN_W             = $clog2(BODY_BYTES + 1);
  localparam int QUEUE_DEPTH       = 2;
  localparam int QPTR_W            = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W            = $clog2(QUEUE_DEPTH + 1);

  // Header codes
  localparam logic [7:0] HDR_SINGLE_READ  = 8'h80;
  localparam logic [7:0] HDR_SINGLE_WRITE = 8'h90;
  localparam logic [7:0] HDR_STACK_READ   = 8'hA0;
  localparam logic [7:0] HDR_STACK_WRITE  = 8'hB0;
  localparam logic [7:0] HDR_BCAST_WRITE  = 8'hD0;
  localparam logic [7:0] LEN_FIELD_MASK   = 8'h07;

  // CRC-16, reflected
  localparam logic [15:0] CRC_SEED = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Command codes
  localparam logic [2:0] ACT_SINGLE_READ  = 3'd0;
  localparam logic [2:0] ACT_STACK_READ   = 3'd1;
  localparam logic [2:0] ACT_SINGLE_WRITE = 3'd2;
  localparam logic [2:0] ACT_STACK_WRITE  = 3'd3;
  localparam logic [2:0] ACT_BCAST_WRITE  = 3'd4;

  // One classified command: frame body bytes in send order and their number
  typedef struct packed {
    logic [BODY_BYTES-1:0][7:0] body;
    logic [LEN_W-1:0]           len;
  } dcf_desc_t;

  // Fold one byte into the CRC, LSB first
  function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== sv/dcf_front.sv =====
// Front end: accept a command, classify it and build the frame body.
module dcf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        in_action,
  input  logic [7:0]        in_device_address,
  input  logic [15:0]       in_register_address,
  input  logic [7:0]        in_byte_count,
  input  logic [63:0]       in_payload,
  input  logic              q_full,
  output logic              q_push,
  output dcf_pkg::dcf_desc_t q_desc
);
  import dcf_pkg::*;

  logic        valid_r, valid_nxt;
  dcf_desc_t   desc_r, desc_nxt;
  logic        accept;
  logic        act_ok, is_single, is_write;
  logic [7:0]  hdr, cnt;

  // Hold the word while the queue is full
  assign busy   = valid_r & q_full;
  assign accept = start & ~busy;
  assign q_push = valid_r & ~q_full;
  assign q_desc = desc_r;

  // Classify the command and lay out the body bytes
  always_comb begin
    hdr       = 8'h00;
    is_single = 1'b0;
    is_write  = 1'b0;
    act_ok    = 1'b1;
    unique case (in_action)
      ACT_SINGLE_READ:  begin hdr = HDR_SINGLE_READ;  is_single = 1'b1; end
      ACT_STACK_READ:   begin hdr = HDR_STACK_READ; end
      ACT_SINGLE_WRITE: begin hdr = HDR_SINGLE_WRITE; is_single = 1'b1; is_write = 1'b1; end
      ACT_STACK_WRITE:  begin hdr = HDR_STACK_WRITE;  is_write = 1'b1; end
      ACT_BCAST_WRITE:  begin hdr = HDR_BCAST_WRITE;  is_write = 1'b1; end
      default:          act_ok = 1'b0;
    endcase

    // Saturate the write count into one to the payload size
    cnt = in_byte_count;
    if (cnt > 8'(MAX_PAYLOAD_BYTES)) begin
      cnt = 8'(MAX_PAYLOAD_BYTES);
    end
    if (cnt == 8'd0) begin
      cnt = 8'd1;
    end
    if (is_write) begin
      hdr = hdr | ((cnt - 8'd1) & LEN_FIELD_MASK);
    end

    desc_nxt.body    = '0;
    desc_nxt.body[0] = hdr;
    if (is_single) begin
      desc_nxt.body[1] = in_device_address;
      desc_nxt.body[2] = in_register_address[15:8];
      desc_nxt.body[3] = in_register_address[7:0];
      if (is_write) begin
        for (int i = 0; i < MAX_PAYLOAD_BYTES; i++) begin
          desc_nxt.body[4+i] = in_payload[8*i +: 8];
        end
      end else begin
        desc_nxt.body[4] = in_byte_count - 8'd1;
      end
    end else begin
      desc_nxt.body[1] = in_register_address[15:8];
      desc_nxt.body[2] = in_register_address[7:0];
      if (is_write) begin
        for (int i = 0; i < MAX_PAYLOAD_BYTES; i++) begin
          desc_nxt.body[3+i] = in_payload[8*i +: 8];
        end
      end else begin
        desc_nxt.body[3] = in_byte_count - 8'd1;
      end
    end
    desc_nxt.len = LEN_W'(3) + LEN_W'(is_single) + (is_write ? LEN_W'(cnt) : LEN_W'(1));
  end

  // Load on accept, drop unknown commands, clear once pushed
  always_comb begin
    if (accept) begin
      valid_nxt = act_ok;
    end else if (q_push) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      desc_r <= desc_nxt;
    end
  end

  // Checks
  a_busy_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> valid_r) else $error("busy without a held word");
  a_push_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && !start) |=> !valid_r) else $error("pushed word not cleared");
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> valid_r && $stable(desc_r)) else $error("stalled word changed");

endmodule

// ===== sv/dcf_queue.sv =====
// Short queue of classified commands between the front and back ends.
module dcf_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  dcf_pkg::dcf_desc_t push_desc,
  input  logic               pop,
  output dcf_pkg::dcf_desc_t head_desc,
  output logic               empty,
  output logic               full
);
  import dcf_pkg::*;

  dcf_desc_t           entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                do_push, do_pop;

  assign empty     = (count_r == '0);
  assign full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign do_push   = push & ~full;
  assign do_pop    = pop & ~empty;
  assign head_desc = entries_r[rd_ptr_r];

  // Advance pointers with wrap
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the word
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_desc;
    end
  end

  // Checks
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full)) else $error("push into full queue");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");
  a_pop_lowers: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push) |=> count_r == $past(count_r) - 1'b1)
    else $error("pop did not lower count");

endmodule

// ===== sv/dcf_back.sv =====
// Back end: shift out the frame body a byte per cycle and append the CRC.
module dcf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  dcf_pkg::dcf_desc_t q_head,
  output logic               q_pop,
  output logic               out_valid,
  output logic [7:0]         out_frame_byte,
  output logic               out_last_byte
);
  import dcf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_BODY   = 4'b0010,
    S_CRC_LO = 4'b0100,
    S_CRC_HI = 4'b1000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [BODY_BYTES-1:0][7:0] shreg_r, shreg_nxt;
  logic [LEN_W-1:0]           left_r, left_nxt;
  logic [15:0]                crc_r, crc_nxt;
  logic                       valid_r, valid_nxt;
  logic                       last_r, last_nxt;
  logic [7:0]                 byte_r, byte_nxt;

  // Take the next frame when idle or on its predecessor's final byte
  assign q_pop = ~q_empty & ((state_r == S_IDLE) | (state_r == S_CRC_HI));

  assign out_valid      = valid_r;
  assign out_frame_byte = byte_r;
  assign out_last_byte  = last_r;

  always_comb begin
    state_nxt = state_r;
    shreg_nxt = shreg_r;
    left_nxt  = left_r;
    crc_nxt   = crc_r;
    valid_nxt = 1'b0;
    last_nxt  = 1'b0;
    byte_nxt  = byte_r;
    unique case (state_r)
      S_IDLE: ;
      // Emit one body byte and fold it into the CRC
      S_BODY: begin
        valid_nxt = 1'b1;
        byte_nxt  = shreg_r[0];
        crc_nxt   = crc_update(crc_r, shreg_r[0]);
        shreg_nxt = {8'h00, shreg_r[BODY_BYTES-1:1]};
        left_nxt  = left_r - 1'b1;
        if (left_r == LEN_W'(1)) begin
          state_nxt = S_CRC_LO;
        end
      end
      S_CRC_LO: begin
        valid_nxt = 1'b1;
        byte_nxt  = crc_r[7:0];
        state_nxt = S_CRC_HI;
      end
      S_CRC_HI: begin
        valid_nxt = 1'b1;
        last_nxt  = 1'b1;
        byte_nxt  = crc_r[15:8];
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    // Load a new frame
    if (q_pop) begin
      state_nxt = S_BODY;
      shreg_nxt = q_head.body;
      left_nxt  = q_head.len;
      crc_nxt   = CRC_SEED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      last_r  <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shreg_r <= shreg_nxt;
    left_r  <= left_nxt;
    crc_r   <= crc_nxt;
    byte_r  <= byte_nxt;
  end

  // Checks
  a_last_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
    last_r |-> valid_r) else $error("last flag without strobe");
  a_crc_lo: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CRC_LO) |=> valid_r && !last_r) else $error("CRC low byte missing");
  a_crc_hi: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CRC_HI) |=> valid_r && last_r) else $error("CRC high byte not last");
  a_body_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BODY) |-> left_r != '0) else $error("body state with no bytes left");

endmodule

// ===== sv/daisy_chain_command_framer.sv =====
// Top level of the daisy-chain command framer.
//
// Command channel: drive the in_ ports and raise start; the word is taken at
// a rising edge where start is high and busy is low. Unknown action codes
// are taken and dropped without a frame.
// Result channel: one frame byte per cycle on out_frame_byte, marked by
// out_valid; out_last_byte flags the CRC high byte that closes the frame.
// The receiver cannot stall, so bytes leave at a steady one per clock.
// On its way to the ports a command passes the front register, the queue,
// the back-end shift register and the output byte register.
// Frame length: a body of 4 to 12 bytes plus two CRC bytes, sent by the
// one-byte-per-cycle shifter and CRC update in the back end. Frames follow
// each other with no gap while the queue holds the next one; a two-word
// queue plus the front register let commands arrive while a frame is out,
// and busy rises only when both are full.
// Reset (rst_n low, synchronous) empties the front register and the queue
// and returns the back end to idle; no byte is sent until a new command.
module daisy_chain_command_framer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_action,
  input  logic [7:0]  in_device_address,
  input  logic [15:0] in_register_address,
  input  logic [7:0]  in_byte_count,
  input  logic [63:0] in_payload,
  output logic        out_valid,
  output logic [7:0]  out_frame_byte,
  output logic        out_last_byte
);
  import dcf_pkg::*;

  dcf_desc_t push_desc, head_desc;
  logic      q_push, q_pop, q_empty, q_full;

  // Accept and classify
  dcf_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_action           (in_action),
    .in_device_address   (in_device_address),
    .in_register_address (in_register_address),
    .in_byte_count       (in_byte_count),
    .in_payload          (in_payload),
    .q_full              (q_full),
    .q_push              (q_push),
    .q_desc              (push_desc)
  );

  // Decouple front and back
  dcf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (push_desc),
    .pop       (q_pop),
    .head_desc (head_desc),
    .empty     (q_empty),
    .full      (q_full)
  );

  // Serialize and append the CRC
  dcf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_head         (head_desc),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_frame_byte (out_frame_byte),
    .out_last_byte  (out_last_byte)
  );

endmodule

// ===== bench/daisy_chain_command_framer_tb.sv =====
// Self-checking testbench for the daisy-chain command framer.
`timescale 1ns / 100ps

module daisy_chain_command_framer_tb;
  import dcf_pkg::*;

  // Action codes the block does not know; words carrying them are dropped
  localparam logic [2:0] ACT_RSVD_LO  = 3'd5;
  localparam logic [2:0] ACT_RSVD_MID = 3'd6;
  localparam logic [2:0] ACT_RSVD_HI  = 3'd7;

  localparam int DIR_ROWS     = 19;
  localparam int PHASE_ITEMS  = 73;
  localparam int REPORT_LIMIT = 10;
  localparam int DRAIN_CYCLES = 24;

  // One command word; hdr_typed marks a row whose header is given by hand
  typedef struct {
    logic [2:0]  action;
    logic [7:0]  dev;
    logic [15:0] reg_address;
    logic [7:0]  count;
    logic [63:0] payload;
    logic        hdr_typed;
    logic [7:0]  hdr;
  } framer_cmd_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_action = '0;
  logic [7:0]  in_device_address = '0;
  logic [15:0] in_register_address = '0;
  logic [7:0]  in_byte_count = '0;
  logic [63:0] in_payload = '0;
  logic        out_valid;
  logic [7:0]  out_frame_byte;
  logic        out_last_byte;

  frame_byte_t frame_expected_q[$];
  int          mismatch_cnt = 0;

  // Directed words: extremes, every action, count wrap and saturation, dropped codes
  framer_cmd_t dir_rows [DIR_ROWS] = '{
    '{ACT_SINGLE_READ,  8'h00, 16'h0000, 8'd1,   64'h0, 1'b1, HDR_SINGLE_READ},
    '{ACT_SINGLE_READ,  8'hFF, 16'hFFFF, 8'd128, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
      HDR_SINGLE_READ},
    // read count zero wraps to 0xFF in the count byte
    '{ACT_STACK_READ,   8'h5A, 16'h0001, 8'd0,   64'h0, 1'b1, HDR_STACK_READ},
    '{ACT_STACK_READ,   8'h00, 16'h8000, 8'd255, 64'h0, 1'b1, HDR_STACK_READ},
    '{ACT_SINGLE_READ,  8'hA5, 16'h5A5A, 8'd129, 64'h0, 1'b0, 8'h00},
    '{ACT_SINGLE_WRITE, 8'h01, 16'h0100, 8'd1,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
      HDR_SINGLE_WRITE},
    '{ACT_SINGLE_WRITE, 8'h80, 16'hFFFF, 8'd8,   64'h0123_4567_89AB_CDEF, 1'b1,
      HDR_SINGLE_WRITE | LEN_FIELD_MASK},
    // write count zero sends one data byte
    '{ACT_STACK_WRITE,  8'h00, 16'h0000, 8'd0,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
      HDR_STACK_WRITE},
    // write counts above eight saturate
    '{ACT_STACK_WRITE,  8'hFF, 16'hA55A, 8'd9,   64'hFEDC_BA98_7654_3210, 1'b1,
      HDR_STACK_WRITE | LEN_FIELD_MASK},
    '{ACT_BCAST_WRITE,  8'h00, 16'hFFFF, 8'd255, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
      HDR_BCAST_WRITE | LEN_FIELD_MASK},
    '{ACT_BCAST_WRITE,  8'hFF, 16'h0000, 8'd128, 64'h0, 1'b1,
      HDR_BCAST_WRITE | LEN_FIELD_MASK},
    '{ACT_BCAST_WRITE,  8'h33, 16'h1234, 8'd3,   64'hDEAD_BEEF_CAFE_F00D, 1'b0, 8'h00},
    // unknown actions: no frame at all
    '{ACT_RSVD_LO,      8'hFF, 16'hFFFF, 8'd8,   64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 8'h00},
    '{ACT_RSVD_MID,     8'h12, 16'h3456, 8'd2,   64'h0, 1'b0, 8'h00},
    '{ACT_RSVD_HI,      8'h00, 16'h0000, 8'd0,   64'h0, 1'b0, 8'h00},
    '{ACT_SINGLE_WRITE, 8'h7E, 16'h00FF, 8'd4,   64'h5555_AAAA_5555_AAAA, 1'b0, 8'h00},
    '{ACT_STACK_READ,   8'hFF, 16'hFF00, 8'd2,   64'h0, 1'b0, 8'h00},
    '{ACT_STACK_WRITE,  8'h00, 16'h7FFF, 8'd5,   64'h8000_0000_0000_0001, 1'b0, 8'h00},
    '{ACT_SINGLE_READ,  8'h3C, 16'hC3C3, 8'd64,  64'h0, 1'b0, 8'h00}
  };

  int phase_idle_pct [4] = '{0, 49, 0, 29};

  daisy_chain_command_framer uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_action           (in_action),
    .in_device_address   (in_device_address),
    .in_register_address (in_register_address),
    .in_byte_count       (in_byte_count),
    .in_payload          (in_payload),
    .out_valid           (out_valid),
    .out_frame_byte      (out_frame_byte),
    .out_last_byte       (out_last_byte)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shift one byte into the CRC-16 register, one data bit at a time
  function automatic logic [15:0] crc16_fold(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    logic        fb;
    c = crc_in;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ data[k];
      c  = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  // Build the frame a command word must produce and queue its bytes
  function automatic void predict_frame(input framer_cmd_t cmd);
    logic [7:0]  frame[$];
    logic [7:0]  hdr;
    logic [15:0] crc;
    logic        is_write;
    logic        is_single;
    int          n_data;
    frame_byte_t fb;
    n_data = 1;
    case (cmd.action)
      ACT_SINGLE_READ: begin
        hdr = HDR_SINGLE_READ;  is_write = 1'b0; is_single = 1'b1;
      end
      ACT_STACK_READ: begin
        hdr = HDR_STACK_READ;   is_write = 1'b0; is_single = 1'b0;
      end
      ACT_SINGLE_WRITE: begin
        hdr = HDR_SINGLE_WRITE; is_write = 1'b1; is_single = 1'b1;
      end
      ACT_STACK_WRITE: begin
        hdr = HDR_STACK_WRITE;  is_write = 1'b1; is_single = 1'b0;
      end
      ACT_BCAST_WRITE: begin
        hdr = HDR_BCAST_WRITE;  is_write = 1'b1; is_single = 1'b0;
      end
      default: return;
    endcase
    // clamp the write length to 1..MAX_PAYLOAD_BYTES and fold it into the header
    if (is_write) begin
      n_data = (cmd.count > MAX_PAYLOAD_BYTES) ? MAX_PAYLOAD_BYTES : int'(cmd.count);
      if (n_data == 0) begin
        n_data = 1;
      end
      hdr = hdr | (8'(n_data - 1) & LEN_FIELD_MASK);
    end
    if (cmd.hdr_typed) begin
      hdr = cmd.hdr;
    end
    frame.push_back(hdr);
    if (is_single) begin
      frame.push_back(cmd.dev);
    end
    frame.push_back(cmd.reg_address[15:8]);
    frame.push_back(cmd.reg_address[7:0]);
    if (is_write) begin
      for (int i = 0; i < n_data; i++) begin
        frame.push_back(cmd.payload[8*i +: 8]);
      end
    end else begin
      frame.push_back(cmd.count - 8'd1);
    end
    crc = CRC_SEED;
    foreach (frame[i]) begin
      crc = crc16_fold(crc, frame[i]);
    end
    frame.push_back(crc[7:0]);
    frame.push_back(crc[15:8]);
    foreach (frame[i]) begin
      fb.data = frame[i];
      fb.last = (i == frame.size() - 1);
      frame_expected_q.push_back(fb);
    end
  endfunction

  // Offer one command word, idling first at the given rate, and wait until it is taken
  task automatic issue_command(input framer_cmd_t cmd, input int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start               <= 1'b1;
    in_action           <= cmd.action;
    in_device_address   <= cmd.dev;
    in_register_address <= cmd.reg_address;
    in_byte_count       <= cmd.count;
    in_payload          <= cmd.payload;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    predict_frame(cmd);
  endtask

  // Draw a random command: mostly known actions with small counts
  function automatic framer_cmd_t random_command();
    framer_cmd_t cmd;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      cmd.action = 3'($urandom_range(ACT_RSVD_LO, ACT_RSVD_HI));
    end else begin
      cmd.action = 3'($urandom_range(ACT_SINGLE_READ, ACT_BCAST_WRITE));
    end
    cmd.dev         = 8'($urandom_range(0, 255));
    cmd.reg_address = 16'($urandom_range(0, 65535));
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      cmd.count = 8'($urandom_range(1, 9));
    end else if (pick < 75) begin
      cmd.count = 8'd0;
    end else begin
      cmd.count = 8'($urandom_range(0, 255));
    end
    cmd.payload   = {$urandom, $urandom};
    cmd.hdr_typed = 1'b0;
    cmd.hdr       = 8'h00;
    return cmd;
  endfunction

  // Compare every strobed byte with the oldest expected one
  always @(posedge clk) begin : check_bytes
    frame_byte_t want;
    if (rst_n && out_valid) begin
      if (frame_expected_q.size() == 0) begin
        if (mismatch_cnt < REPORT_LIMIT) begin
          $display("unexpected byte: data %02h last %0b", out_frame_byte, out_last_byte);
        end
        mismatch_cnt++;
      end else begin
        want = frame_expected_q.pop_front();
        if (want.data !== out_frame_byte || want.last !== out_last_byte) begin
          if (mismatch_cnt < REPORT_LIMIT) begin
            $display("byte mismatch: expected data %02h last %0b, got data %02h last %0b",
                     want.data, want.last, out_frame_byte, out_last_byte);
          end
          mismatch_cnt++;
        end
      end
    end
  end

  // Stimulus: directed table, then random phases with varying sender gaps
  initial begin : drive_commands
    framer_cmd_t cmd;
    int          taken;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int r = 0; r < DIR_ROWS; r++) begin
      issue_command(dir_rows[r], 0);
    end
    for (int ph = 0; ph < 4; ph++) begin
      taken = 0;
      while (taken < PHASE_ITEMS) begin
        cmd = random_command();
        issue_command(cmd, phase_idle_pct[ph]);
        taken++;
      end
    end
    start <= 1'b0;
    // drain outstanding frames, then watch for stray bytes
    while (frame_expected_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && frame_expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hang guard
  initial begin : watchdog
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/dcf_pkg.sv
sv/dcf_front.sv
sv/dcf_queue.sv
sv/dcf_back.sv
sv/daisy_chain_command_framer.sv
bench/daisy_chain_command_framer_tb.sv
